// ----- rtl/mcfl_pkg.sv -----
package mcfl_pkg;

  // frame constants
  localparam logic [7:0] FRAME_HDR  = 8'hA5;
  localparam logic [7:0] LINK_ACK   = 8'h06;
  localparam logic [7:0] OP_READ_A  = 8'h44;
  localparam logic [7:0] OP_READ_B  = 8'h52;
  localparam logic [7:0] OP_READ_C  = 8'h4E;
  localparam logic [7:0] FRAME_OVH  = 8'd3;
  localparam logic [7:0] IDX_OPCODE = 8'd3;
  localparam logic [7:0] IDX_RLEN   = 8'd4;

  // request kinds on the input channel
  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BODY  = 2'd1,
    MODE_RX    = 2'd2
  } mode_t;

  // transaction status codes
  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_ACK_OK   = 3'd1,
    ST_REPLY_OK = 3'd2,
    ST_LEN_ERR  = 3'd3,
    ST_SUM_ERR  = 3'd4,
    ST_TOO_LONG = 3'd5
  } status_t;

  // one result request
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    status_t    status;
    logic [7:0] reply_count;
    logic       last;
  } res_t;

  localparam int MAX_RES = 3;

  // handoff from step logic to result buffer
  typedef struct packed {
    logic       load;
    logic [1:0] cnt;
  } push_t;

  function automatic res_t mk_tx(input logic [7:0] b);
    res_t r;
    r          = '0;
    r.tx_valid = 1'b1;
    r.tx_byte  = b;
    return r;
  endfunction

  function automatic res_t mk_rx(input logic [7:0] b);
    res_t r;
    r          = '0;
    r.rx_valid = 1'b1;
    r.rx_byte  = b;
    return r;
  endfunction

  function automatic res_t mk_done(input status_t st, input logic [7:0] cnt);
    res_t r;
    r             = '0;
    r.done_res    = 1'b1;
    r.status      = st;
    r.reply_count = cnt;
    return r;
  endfunction

endpackage

// ----- rtl/mcfl_in_if.sv -----
interface mcfl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic [7:0] body_length;

  modport source (output valid, output mode, output data_byte, output body_length,
                  input ready);
  modport sink (input valid, input mode, input data_byte, input body_length,
                output ready);
endinterface

// ----- rtl/mcfl_out_if.sv -----
interface mcfl_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       done_res;
  logic [2:0] status;
  logic [7:0] reply_count;
  logic       last;

  modport source (output valid, output tx_valid, output tx_byte, output rx_valid,
                  output rx_byte, output done_res, output status,
                  output reply_count, output last, input ready);
  modport sink (input valid, input tx_valid, input tx_byte, input rx_valid,
                input rx_byte, input done_res, input status,
                input reply_count, input last, output ready);
endinterface

// ----- rtl/mcfl_core.sv -----
module mcfl_core
  import mcfl_pkg::*;
#(
  parameter int MAX_FRAME = 80
) (
  input  logic              clk,
  input  logic              rst,
  mcfl_in_if.sink           in_ch,
  input  logic              buf_free,
  output push_t             push,
  output res_t [MAX_RES-1:0] bundle
);

  localparam logic [7:0] BODY_MAX = 8'(MAX_FRAME - 3);

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_BODY = 6'b000010,
    PH_ACK  = 6'b000100,
    PH_LEN  = 6'b001000,
    PH_DATA = 6'b010000,
    PH_SUM  = 6'b100000
  } phase_t;

  // input register
  logic       in_vld;
  logic [1:0] in_mode;
  logic [7:0] in_byte;
  logic [7:0] in_blen;

  // transaction state
  phase_t     phase, phase_next;
  logic [7:0] tx_sum, tx_sum_next;
  logic [7:0] rx_sum, rx_sum_next;
  logic [7:0] body_total, body_total_next;
  logic [7:0] body_index, body_index_next;
  logic       is_read, is_read_next;
  logic [7:0] exp_len, exp_len_next;
  logic [7:0] reply_len, reply_len_next;
  logic [7:0] data_seen, data_seen_next;

  logic [1:0]           n_res;
  res_t [MAX_RES-1:0]   res;
  logic                 take;
  logic [7:0]           sum_a, sum_b, idx_inc, seen_inc, data_len;

  assign take         = in_vld && ((n_res == 2'd0) || buf_free);
  assign in_ch.ready  = !in_vld || take;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= (in_ch.valid && in_ch.ready) || (in_vld && !take);
    end
    if (in_ch.valid && in_ch.ready) begin
      in_mode <= in_ch.mode;
      in_byte <= in_ch.data_byte;
      in_blen <= in_ch.body_length;
    end
  end

  // running sums and counters
  assign sum_a    = 8'(FRAME_HDR + 8'(in_blen + FRAME_OVH));
  assign sum_b    = 8'(tx_sum + in_byte);
  assign idx_inc  = 8'(body_index + 8'd1);
  assign seen_inc = 8'(data_seen + 8'd1);
  assign data_len = 8'(reply_len - FRAME_OVH);

  // step logic for one request
  always_comb begin
    phase_next      = phase;
    tx_sum_next     = tx_sum;
    rx_sum_next     = rx_sum;
    body_total_next = body_total;
    body_index_next = body_index;
    is_read_next    = is_read;
    exp_len_next    = exp_len;
    reply_len_next  = reply_len;
    data_seen_next  = data_seen;
    n_res           = 2'd0;
    res             = '0;
    case (in_mode)
      MODE_START: begin
        is_read_next    = 1'b0;
        exp_len_next    = '0;
        body_index_next = '0;
        tx_sum_next     = '0;
        if (in_blen > BODY_MAX) begin
          body_total_next = '0;
          res[0]          = mk_done(ST_TOO_LONG, 8'd0);
          n_res           = 2'd1;
          phase_next      = PH_IDLE;
        end else begin
          body_total_next = in_blen;
          res[0]          = mk_tx(FRAME_HDR);
          res[1]          = mk_tx(8'(in_blen + FRAME_OVH));
          tx_sum_next     = sum_a;
          if (in_blen == 8'd0) begin
            res[2]     = mk_tx(sum_a);
            n_res      = 2'd3;
            phase_next = PH_ACK;
          end else begin
            n_res      = 2'd2;
            phase_next = PH_BODY;
          end
        end
      end
      MODE_BODY: begin
        if (phase == PH_BODY) begin
          if (body_index == IDX_OPCODE) begin
            is_read_next = (in_byte == OP_READ_A) || (in_byte == OP_READ_B) ||
                           (in_byte == OP_READ_C);
          end
          if (body_index == IDX_RLEN && is_read) begin
            exp_len_next = 8'(in_byte + FRAME_OVH);
          end
          res[0]          = mk_tx(in_byte);
          tx_sum_next     = sum_b;
          body_index_next = idx_inc;
          if (idx_inc >= body_total) begin
            res[1]     = mk_tx(sum_b);
            n_res      = 2'd2;
            phase_next = PH_ACK;
          end else begin
            n_res = 2'd1;
          end
        end
      end
      MODE_RX: begin
        case (phase)
          PH_ACK: begin
            if (in_byte == LINK_ACK) begin
              if (is_read) begin
                rx_sum_next = LINK_ACK;
                phase_next  = PH_LEN;
              end else begin
                res[0]     = mk_done(ST_ACK_OK, 8'd0);
                n_res      = 2'd1;
                phase_next = PH_IDLE;
              end
            end
          end
          PH_LEN: begin
            reply_len_next = in_byte;
            if ((exp_len != 8'd0 && in_byte != exp_len) || in_byte < FRAME_OVH) begin
              res[0]     = mk_done(ST_LEN_ERR, 8'd0);
              n_res      = 2'd1;
              phase_next = PH_IDLE;
            end else begin
              rx_sum_next    = 8'(rx_sum + in_byte);
              data_seen_next = '0;
              phase_next     = (in_byte == FRAME_OVH) ? PH_SUM : PH_DATA;
            end
          end
          PH_DATA: begin
            res[0]         = mk_rx(in_byte);
            n_res          = 2'd1;
            rx_sum_next    = 8'(rx_sum + in_byte);
            data_seen_next = seen_inc;
            if (seen_inc >= data_len) begin
              phase_next = PH_SUM;
            end
          end
          PH_SUM: begin
            if (rx_sum == in_byte) begin
              res[0] = mk_done(ST_REPLY_OK, data_len);
            end else begin
              res[0] = mk_done(ST_SUM_ERR, 8'd0);
            end
            n_res      = 2'd1;
            phase_next = PH_IDLE;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    // mark the last result of this request
    case (n_res)
      2'd1:    res[0].last = 1'b1;
      2'd2:    res[1].last = 1'b1;
      2'd3:    res[2].last = 1'b1;
      default: begin
      end
    endcase
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tx_sum     <= '0;
      rx_sum     <= '0;
      body_total <= '0;
      body_index <= '0;
      is_read    <= 1'b0;
      exp_len    <= '0;
      reply_len  <= '0;
      data_seen  <= '0;
    end else if (take) begin
      phase      <= phase_next;
      tx_sum     <= tx_sum_next;
      rx_sum     <= rx_sum_next;
      body_total <= body_total_next;
      body_index <= body_index_next;
      is_read    <= is_read_next;
      exp_len    <= exp_len_next;
      reply_len  <= reply_len_next;
      data_seen  <= data_seen_next;
    end
  end

  assign push.load = take && (n_res != 2'd0);
  assign push.cnt  = n_res;
  assign bundle    = res;

`ifndef SYNTH
  // body phase never runs past the announced body length
  a_body_idx: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> body_index < body_total)
    else $error("body index past body length");

  // an oversized start always drops back to idle
  a_too_long: assert property (@(posedge clk) disable iff (rst)
    take && in_mode == MODE_START && in_blen > BODY_MAX |=> phase == PH_IDLE)
    else $error("oversized start did not return to idle");
`endif

endmodule

// ----- rtl/mcfl_emit.sv -----
module mcfl_emit
  import mcfl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  push_t              push,
  input  res_t [MAX_RES-1:0] bundle,
  output logic               buf_free,
  mcfl_out_if.source         out_ch
);

  logic [1:0]         cnt;
  res_t [MAX_RES-1:0] slot;
  logic               pop;

  assign pop      = (cnt != 2'd0) && out_ch.ready;
  assign buf_free = (cnt == 2'd0) || ((cnt == 2'd1) && out_ch.ready);

  // result buffer: load a whole bundle, drain one result per cycle while the output is ready
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (push.load) begin
      cnt <= push.cnt;
    end else if (pop) begin
      cnt <= 2'(cnt - 2'd1);
    end
    if (push.load) begin
      slot <= bundle;
    end else if (pop) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  // output drive from the head slot
  assign out_ch.valid       = (cnt != 2'd0);
  assign out_ch.tx_valid    = slot[0].tx_valid;
  assign out_ch.tx_byte     = slot[0].tx_byte;
  assign out_ch.rx_valid    = slot[0].rx_valid;
  assign out_ch.rx_byte     = slot[0].rx_byte;
  assign out_ch.done_res    = slot[0].done_res;
  assign out_ch.status      = slot[0].status;
  assign out_ch.reply_count = slot[0].reply_count;
  assign out_ch.last        = slot[0].last;

`ifndef SYNTH
  // a new bundle only lands when the buffer is empty or drains its last entry this cycle
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push.load |-> buf_free)
    else $error("bundle loaded over pending results");

  // the final entry of a bundle carries the last mark
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && cnt == 2'd1 |-> out_ch.last)
    else $error("final buffered result lacks last mark");
`endif

endmodule

// ----- rtl/meter_command_frame_link.sv -----
// Command frame link for a power-meter serial port. A start request (mode 0)
// frames a command: header 0xA5 and total length go out at once, each body
// request (mode 1) sends its byte, and the checksum follows the last body byte.
// Link bytes (mode 2) then walk the reply through ACK and, for a read command,
// length, data and checksum, ending in one done result with a status. Each
// input request passes through a one-deep input register and the step logic;
// its results (up to three) sit in a three-entry result buffer that drives one
// result per cycle while the output is ready, so a new request is taken every
// cycle except after one that makes several results (a start, or the last body
// byte with its checksum): the next request then waits until the buffer has
// drained them. MAX_FRAME sets the longest frame.
module meter_command_frame_link
  import mcfl_pkg::*;
#(
  parameter int MAX_FRAME = 80
) (
  input  logic       clk,
  input  logic       rst,
  mcfl_in_if.sink    in_ch,
  mcfl_out_if.source out_ch
);

  push_t              push;
  res_t [MAX_RES-1:0] bundle;
  logic               buf_free;

  // frame and reply step logic
  mcfl_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .buf_free (buf_free),
    .push     (push),
    .bundle   (bundle)
  );

  // result buffer
  mcfl_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .bundle   (bundle),
    .buf_free (buf_free),
    .out_ch   (out_ch)
  );

endmodule
